// ----- rtl/scc_pkg.sv -----
// Shared package of the strongly connected components block.
// Holds the field widths, beat codes and default sizes; it depends on nothing.
package scc_pkg;

    localparam int unsigned CFG_W       = 11;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned NODE_FLD_W  = 11;
    localparam int unsigned RKIND_W     = 3;

    localparam int unsigned MAX_NODES_DEF = 1024;
    localparam int unsigned MAX_EDGES_DEF = 8192;

    typedef enum logic [KIND_W-1:0] {
        K_ADD  = 2'd0,
        K_COMP = 2'd1,
        K_READ = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [RKIND_W-1:0] {
        R_STORED = 3'd0,
        R_REJECT = 3'd1,
        R_COUNT  = 3'd2,
        R_MEMBER = 3'd3,
        R_END    = 3'd4,
        R_NOMORE = 3'd5
    } t_rkind;

endpackage

// ----- rtl/scc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for every store of the strongly connected components block; no dependencies.
module scc_ram #(
    parameter int unsigned W  = 8,
    parameter int unsigned D  = 16,
    parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/strongly_connected_components.sv -----
// Top level of the strongly connected components block (Kosaraju's method).
// Depends on scc_pkg and on scc_ram for the head, edge, node, stack and finish stores.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      i_kind, i_edge_from, i_edge_to
//  result    out        o_out_valid / i_out_stall    o_result_kind, o_value, o_final_word
//  config    in         i_cfg_we                     i_cfg_data
//
// An edge beat is stored in S_ADD and then answered in S_RES, or answered in S_RES at once when it
// is rejected; a compute beat clears the labels of all MAX_NODES nodes, then walks every node and
// edge over the two passes, its pace set by the one node store port.
// A read beat reads and checks the node store one node after another.
// After reset a clearing pass over all MAX_NODES entries empties the head stores; input stalls.
// One beat is worked at a time; a finished result waits in the output register.
module strongly_connected_components #(
    parameter int unsigned MAX_NODES = scc_pkg::MAX_NODES_DEF,
    parameter int unsigned MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [scc_pkg::KIND_W-1:0]      i_kind,
    input  logic [scc_pkg::NODE_FLD_W-1:0]  i_edge_from,
    input  logic [scc_pkg::NODE_FLD_W-1:0]  i_edge_to,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [scc_pkg::RKIND_W-1:0]     o_result_kind,
    output logic [scc_pkg::NODE_FLD_W-1:0]  o_value,
    output logic                            o_final_word,
    input  logic                            i_cfg_we,
    input  logic [scc_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int unsigned NW  = $clog2(MAX_NODES + 1);
    localparam int unsigned PW  = $clog2(MAX_NODES + 2);
    localparam int unsigned AW  = $clog2(MAX_NODES);
    localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
    localparam int unsigned AE  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned FW  = scc_pkg::NODE_FLD_W;
    localparam int unsigned XW  = (NW > scc_pkg::CFG_W) ? NW : scc_pkg::CFG_W;
    localparam int unsigned EDW = 2 * NW + 2 * EW;
    localparam int unsigned NMW = NW + 2;
    localparam int unsigned STW = NW + EW;

    typedef enum logic [17:0] {
        S_CLR   = 18'h00001,
        S_IDLE  = 18'h00002,
        S_ADD   = 18'h00004,
        S_CCLR  = 18'h00008,
        S_FSEL  = 18'h00010,
        S_FCHK  = 18'h00020,
        S_TOP   = 18'h00040,
        S_EDGE  = 18'h00080,
        S_VIS   = 18'h00100,
        S_POP   = 18'h00200,
        S_RSEL  = 18'h00400,
        S_RNODE = 18'h00800,
        S_RCHK  = 18'h01000,
        S_PRD   = 18'h02000,
        S_PCHK  = 18'h04000,
        S_MRD   = 18'h08000,
        S_MCHK  = 18'h10000,
        S_RES   = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic [scc_pkg::CFG_W-1:0] r_cfg;
    logic [EW-1:0] r_etot, n_etot;
    logic [AW-1:0] r_clr, n_clr;
    logic [NW-1:0] r_s, n_s;
    logic [NW-1:0] r_tn, n_tn;
    logic [EW-1:0] r_tc, n_tc;
    logic [NW-1:0] r_sp, n_sp;
    logic [NW-1:0] r_fin, n_fin;
    logic [NW-1:0] r_comps, n_comps;
    logic [NW-1:0] r_v, n_v;
    logic          r_rev, n_rev;
    logic          r_have, n_have;
    logic [PW-1:0] r_lp, n_lp;
    logic          r_pfin, n_pfin;
    logic [NW-1:0] r_rlab, n_rlab;
    logic [PW-1:0] r_rpos, n_rpos;
    logic [FW-1:0] r_from, n_from;
    logic [FW-1:0] r_to, n_to;
    scc_pkg::t_rkind r_rk, n_rk;
    logic [FW-1:0] r_rv, n_rv;
    logic          r_rf, n_rf;
    logic          r_ov, n_ov;
    logic [scc_pkg::RKIND_W-1:0] r_ok, n_ok;
    logic [FW-1:0] r_oval, n_oval;
    logic          r_ofin, n_ofin;

    logic          fh_we, rh_we, em_we, nm_we, st_we, fo_we;
    logic [AW-1:0] fh_wa, fh_ra, rh_wa, rh_ra, nm_wa, nm_ra, st_wa, st_ra, fo_wa, fo_ra;
    logic [AE-1:0] em_wa, em_ra;
    logic [EW-1:0] fh_wd, fh_rd, rh_wd, rh_rd;
    logic [EDW-1:0] em_wd, em_rd;
    logic [NMW-1:0] nm_wd, nm_rd;
    logic [STW-1:0] st_wd, st_rd;
    logic [NW-1:0]  fo_wd, fo_rd;

    logic [NW-1:0] n_eff;
    logic          in_acc;
    logic          from_ok, to_ok;
    logic [NW-1:0] e_src, e_dst, nm_lab;
    logic [EW-1:0] e_fl, e_rl;
    logic          nm_seen, nm_emit, vis_ok;

    assign n_eff = (XW'(r_cfg) > XW'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(r_cfg);
    assign in_acc = i_in_valid && !o_in_stall;
    assign from_ok = (i_edge_from != '0) && (XW'(i_edge_from) <= XW'(n_eff));
    assign to_ok = (i_edge_to != '0) && (XW'(i_edge_to) <= XW'(n_eff));
    assign e_src = em_rd[EDW-1:NW+2*EW];
    assign e_dst = em_rd[NW+2*EW-1:2*EW];
    assign e_fl = em_rd[2*EW-1:EW];
    assign e_rl = em_rd[EW-1:0];
    assign nm_lab = nm_rd[NMW-1:2];
    assign nm_seen = nm_rd[1];
    assign nm_emit = nm_rd[0];
    assign vis_ok = (r_v <= n_eff) && (r_sp < NW'(MAX_NODES))
                    && (r_rev ? (nm_lab == '0) : !nm_seen);

    always_comb begin
        n_state = r_state;
        n_etot = r_etot;
        n_clr = r_clr;
        n_s = r_s;
        n_tn = r_tn;
        n_tc = r_tc;
        n_sp = r_sp;
        n_fin = r_fin;
        n_comps = r_comps;
        n_v = r_v;
        n_rev = r_rev;
        n_have = r_have;
        n_lp = r_lp;
        n_pfin = r_pfin;
        n_rlab = r_rlab;
        n_rpos = r_rpos;
        n_from = r_from;
        n_to = r_to;
        n_rk = r_rk;
        n_rv = r_rv;
        n_rf = r_rf;
        n_ov = r_ov && i_out_stall;
        n_ok = r_ok;
        n_oval = r_oval;
        n_ofin = r_ofin;
        fh_we = 1'b0; fh_wa = '0; fh_wd = '0; fh_ra = '0;
        rh_we = 1'b0; rh_wa = '0; rh_wd = '0; rh_ra = '0;
        em_we = 1'b0; em_wa = '0; em_wd = '0; em_ra = '0;
        nm_we = 1'b0; nm_wa = '0; nm_wd = '0; nm_ra = '0;
        st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
        fo_we = 1'b0; fo_wa = '0; fo_wd = '0; fo_ra = '0;

        unique case (r_state)
            S_CLR: begin
                fh_we = 1'b1;
                fh_wa = r_clr;
                rh_we = 1'b1;
                rh_wa = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                fh_ra = AW'(XW'(i_edge_from) - XW'(1));
                rh_ra = AW'(XW'(i_edge_to) - XW'(1));
                if (in_acc) begin
                    n_rf = 1'b0;
                    n_rv = '0;
                    unique case (i_kind)
                        scc_pkg::K_ADD: begin
                            n_from = i_edge_from;
                            n_to = i_edge_to;
                            if (from_ok && to_ok && (r_etot < EW'(MAX_EDGES))) begin
                                n_state = S_ADD;
                            end else begin
                                n_rk = scc_pkg::R_REJECT;
                                n_state = S_RES;
                            end
                        end
                        scc_pkg::K_COMP: begin
                            n_clr = '0;
                            n_fin = '0;
                            n_comps = '0;
                            n_s = NW'(1);
                            n_rev = 1'b0;
                            n_have = 1'b1;
                            n_lp = PW'(1);
                            n_rlab = '0;
                            n_rpos = '0;
                            n_state = S_CCLR;
                        end
                        scc_pkg::K_READ: begin
                            if (!r_have) begin
                                n_rk = scc_pkg::R_NOMORE;
                                n_state = S_RES;
                            end else if (r_rlab == '0) begin
                                n_pfin = 1'b0;
                                n_state = S_PRD;
                            end else begin
                                n_state = S_MRD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                em_we = 1'b1;
                em_wa = AE'(r_etot);
                em_wd = {NW'(r_from), NW'(r_to), fh_rd, rh_rd};
                fh_we = 1'b1;
                fh_wa = AW'(XW'(r_from) - XW'(1));
                fh_wd = r_etot + EW'(1);
                rh_we = 1'b1;
                rh_wa = AW'(XW'(r_to) - XW'(1));
                rh_wd = r_etot + EW'(1);
                n_etot = r_etot + EW'(1);
                n_rk = scc_pkg::R_STORED;
                n_state = S_RES;
            end
            S_CCLR: begin
                nm_we = 1'b1;
                nm_wa = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(MAX_NODES - 1)) begin
                    if (n_eff == '0) begin
                        n_rev = 1'b1;
                        n_state = S_RSEL;
                    end else begin
                        n_state = S_FSEL;
                    end
                end
            end
            S_FSEL: begin
                nm_ra = AW'(r_s - NW'(1));
                fh_ra = AW'(r_s - NW'(1));
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (nm_seen) begin
                    if (r_s == n_eff) begin
                        n_rev = 1'b1;
                        n_state = S_RSEL;
                    end else begin
                        n_s = r_s + NW'(1);
                        n_state = S_FSEL;
                    end
                end else begin
                    nm_we = 1'b1;
                    nm_wa = AW'(r_s - NW'(1));
                    nm_wd = {NW'(0), 1'b1, 1'b0};
                    n_tn = r_s;
                    n_tc = fh_rd;
                    n_sp = NW'(1);
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                if (r_tc == '0) begin
                    if (!r_rev) begin
                        fo_we = 1'b1;
                        fo_wa = AW'(r_fin);
                        fo_wd = r_tn;
                        n_fin = r_fin + NW'(1);
                    end
                    if (r_sp == NW'(1)) begin
                        n_sp = '0;
                        if (r_rev) begin
                            n_state = S_RSEL;
                        end else if (r_s == n_eff) begin
                            n_rev = 1'b1;
                            n_state = S_RSEL;
                        end else begin
                            n_s = r_s + NW'(1);
                            n_state = S_FSEL;
                        end
                    end else begin
                        st_ra = AW'(r_sp - NW'(2));
                        n_sp = r_sp - NW'(1);
                        n_state = S_POP;
                    end
                end else begin
                    em_ra = AE'(r_tc - EW'(1));
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                n_v = r_rev ? e_src : e_dst;
                n_tc = r_rev ? e_rl : e_fl;
                nm_ra = AW'((r_rev ? e_src : e_dst) - NW'(1));
                fh_ra = AW'(e_dst - NW'(1));
                rh_ra = AW'(e_src - NW'(1));
                n_state = S_VIS;
            end
            S_VIS: begin
                if (vis_ok) begin
                    nm_we = 1'b1;
                    nm_wa = AW'(r_v - NW'(1));
                    nm_wd = r_rev ? {r_comps, nm_seen, 1'b0} : {NW'(0), 1'b1, 1'b0};
                    st_we = 1'b1;
                    st_wa = AW'(r_sp - NW'(1));
                    st_wd = {r_tn, r_tc};
                    n_tn = r_v;
                    n_tc = r_rev ? rh_rd : fh_rd;
                    n_sp = r_sp + NW'(1);
                end
                n_state = S_TOP;
            end
            S_POP: begin
                n_tn = st_rd[STW-1:EW];
                n_tc = st_rd[EW-1:0];
                n_state = S_TOP;
            end
            S_RSEL: begin
                if (r_fin == '0) begin
                    n_rk = scc_pkg::R_COUNT;
                    n_rv = FW'(r_comps);
                    n_state = S_RES;
                end else begin
                    fo_ra = AW'(r_fin - NW'(1));
                    n_fin = r_fin - NW'(1);
                    n_state = S_RNODE;
                end
            end
            S_RNODE: begin
                n_v = fo_rd;
                nm_ra = AW'(fo_rd - NW'(1));
                rh_ra = AW'(fo_rd - NW'(1));
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if ((r_v > n_eff) || (nm_lab != '0)) begin
                    n_state = S_RSEL;
                end else begin
                    n_comps = r_comps + NW'(1);
                    nm_we = 1'b1;
                    nm_wa = AW'(r_v - NW'(1));
                    nm_wd = {r_comps + NW'(1), nm_seen, 1'b0};
                    n_tn = r_v;
                    n_tc = rh_rd;
                    n_sp = NW'(1);
                    n_state = S_TOP;
                end
            end
            S_PRD: begin
                if (r_lp > PW'(MAX_NODES)) begin
                    n_rk = r_pfin ? scc_pkg::R_END : scc_pkg::R_NOMORE;
                    n_rf = r_pfin;
                    n_state = S_RES;
                end else begin
                    nm_ra = AW'(r_lp - PW'(1));
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if ((nm_lab != '0) && !nm_emit) begin
                    if (r_pfin) begin
                        n_rk = scc_pkg::R_END;
                        n_rf = 1'b0;
                        n_state = S_RES;
                    end else begin
                        n_rlab = nm_lab;
                        n_rpos = r_lp;
                        n_state = S_MRD;
                    end
                end else begin
                    n_lp = r_lp + PW'(1);
                    n_state = S_PRD;
                end
            end
            S_MRD: begin
                if (r_rpos > PW'(MAX_NODES)) begin
                    n_rlab = '0;
                    n_rpos = '0;
                    n_pfin = 1'b1;
                    n_state = S_PRD;
                end else begin
                    nm_ra = AW'(r_rpos - PW'(1));
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                n_rpos = r_rpos + PW'(1);
                if ((nm_lab == r_rlab) && !nm_emit) begin
                    nm_we = 1'b1;
                    nm_wa = AW'(r_rpos - PW'(1));
                    nm_wd = {nm_lab, nm_seen, 1'b1};
                    n_rk = scc_pkg::R_MEMBER;
                    n_rv = FW'(r_rpos);
                    n_state = S_RES;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_RES: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_ok = r_rk;
                    n_oval = r_rv;
                    n_ofin = r_rf;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_cfg <= scc_pkg::CFG_W'(1);
            r_etot <= '0;
            r_have <= 1'b0;
            r_rlab <= '0;
            r_rpos <= '0;
            r_lp <= '0;
            r_ov <= 1'b0;
            r_sp <= '0;
            r_comps <= '0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_etot <= n_etot;
            r_have <= n_have;
            r_rlab <= n_rlab;
            r_rpos <= n_rpos;
            r_lp <= n_lp;
            r_ov <= n_ov;
            r_sp <= n_sp;
            r_comps <= n_comps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_tn <= n_tn;
        r_tc <= n_tc;
        r_fin <= n_fin;
        r_v <= n_v;
        r_rev <= n_rev;
        r_pfin <= n_pfin;
        r_from <= n_from;
        r_to <= n_to;
        r_rk <= n_rk;
        r_rv <= n_rv;
        r_rf <= n_rf;
        r_ok <= n_ok;
        r_oval <= n_oval;
        r_ofin <= n_ofin;
    end

    scc_ram #(.W(EW), .D(MAX_NODES), .AW(AW)) u_fhead (
        .i_clk(i_clk), .i_we(fh_we), .i_waddr(fh_wa), .i_wdata(fh_wd),
        .i_raddr(fh_ra), .o_rdata(fh_rd)
    );

    scc_ram #(.W(EW), .D(MAX_NODES), .AW(AW)) u_rhead (
        .i_clk(i_clk), .i_we(rh_we), .i_waddr(rh_wa), .i_wdata(rh_wd),
        .i_raddr(rh_ra), .o_rdata(rh_rd)
    );

    scc_ram #(.W(EDW), .D(MAX_EDGES), .AW(AE)) u_edges (
        .i_clk(i_clk), .i_we(em_we), .i_waddr(em_wa), .i_wdata(em_wd),
        .i_raddr(em_ra), .o_rdata(em_rd)
    );

    scc_ram #(.W(NMW), .D(MAX_NODES), .AW(AW)) u_nodes (
        .i_clk(i_clk), .i_we(nm_we), .i_waddr(nm_wa), .i_wdata(nm_wd),
        .i_raddr(nm_ra), .o_rdata(nm_rd)
    );

    scc_ram #(.W(STW), .D(MAX_NODES), .AW(AW)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd)
    );

    scc_ram #(.W(NW), .D(MAX_NODES), .AW(AW)) u_finish (
        .i_clk(i_clk), .i_we(fo_we), .i_waddr(fo_wa), .i_wdata(fo_wd),
        .i_raddr(fo_ra), .o_rdata(fo_rd)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_result_kind = r_ok;
    assign o_value = r_oval;
    assign o_final_word = r_ofin;

`ifndef NO_ASSERTIONS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= NW'(MAX_NODES))
        else $error("walk stack depth beyond node capacity");

    a_etot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_etot <= EW'(MAX_EDGES))
        else $error("edge count beyond edge capacity");

    a_comp_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_kind == scc_pkg::K_COMP)) |=> (r_state == S_CCLR))
        else $error("compute beat did not start the label clear");

    a_label_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rlab <= r_comps)
        else $error("read-out label beyond component count");

    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RES) && !r_ov) |=> (r_ov && (r_state == S_IDLE)))
        else $error("result not moved to the output register");
`endif

endmodule
